>>> rtl/vnt_pkg.sv
// Shared constants, state type and corner bundle for the value noise turbulence block.
`timescale 1ns / 1ps
`default_nettype none

package vnt_pkg;

    // Default geometry and arithmetic precision.
    localparam int LATTICE_SIZE_DEF = 64;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_OCTAVES_DEF  = 7;

    // Fixed field widths of the ports.
    localparam int VAL_W   = 16;
    localparam int OUT_W   = 17;
    localparam int CFG_W   = 3;
    localparam int IDX_W   = 12;
    localparam int COORD_W = 32;

    // Octave count after reset.
    localparam logic [CFG_W-1:0] OCT_RESET = 3'd3;

    // Item kinds carried by the mode field.
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // The four lattice corners around one sample point.
    typedef struct packed {
        logic [VAL_W-1:0] c00;
        logic [VAL_W-1:0] c10;
        logic [VAL_W-1:0] c01;
        logic [VAL_W-1:0] c11;
    } t_corners;

endpackage

`default_nettype wire

>>> rtl/vnt_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module vnt_ram #(
    parameter int WIDTH = vnt_pkg::VAL_W,
    parameter int DEPTH = vnt_pkg::LATTICE_SIZE_DEF * vnt_pkg::LATTICE_SIZE_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]         o_rd_data_a,
    output logic      [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Both read ports return data in the cycle after the address.
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

>>> rtl/vnt_lattice.sv
// Lattice store: two mirrored RAMs that return all four corners of a cell per cycle.
`timescale 1ns / 1ps
`default_nettype none

module vnt_lattice #(
    parameter int LATTICE_SIZE = vnt_pkg::LATTICE_SIZE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [vnt_pkg::IDX_W-1:0]      i_wr_index,
    input  wire logic [vnt_pkg::VAL_W-1:0]      i_wr_value,
    input  wire logic [$clog2(LATTICE_SIZE)-1:0] i_row,
    input  wire logic [$clog2(LATTICE_SIZE)-1:0] i_col,
    output vnt_pkg::t_corners                   o_corners
);

    localparam int IW    = $clog2(LATTICE_SIZE);
    localparam int CELLS = LATTICE_SIZE * LATTICE_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam logic [IW-1:0] WRAP = IW'(LATTICE_SIZE - 1);

    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [IW-1:0] row0, row1, col0, col1;
    logic [AW-1:0] addr00, addr10, addr01, addr11;
    logic [vnt_pkg::VAL_W-1:0] rd00, rd10, rd01, rd11;

    // Writes beyond the lattice are dropped.
    assign wr_ok   = i_wr_en && (32'(i_wr_index) < 32'(CELLS));
    assign wr_addr = AW'(i_wr_index);

    // Wrapped row and column of the cell and of its far edges.
    assign row0 = i_row & WRAP;
    assign row1 = IW'(i_row + IW'(1)) & WRAP;
    assign col0 = i_col & WRAP;
    assign col1 = IW'(i_col + IW'(1)) & WRAP;

    // Linear entry addresses, row times lattice size plus column.
    assign addr00 = AW'(row0) * AW'(LATTICE_SIZE) + AW'(col0);
    assign addr10 = AW'(row1) * AW'(LATTICE_SIZE) + AW'(col0);
    assign addr01 = AW'(row0) * AW'(LATTICE_SIZE) + AW'(col1);
    assign addr11 = AW'(row1) * AW'(LATTICE_SIZE) + AW'(col1);

    // Gather the four corner reads into one bundle.
    assign o_corners = {rd00, rd10, rd01, rd11};

    // Copy A serves the near column, copy B the far column; both take every write.
    vnt_ram #(
        .WIDTH (vnt_pkg::VAL_W),
        .DEPTH (CELLS)
    ) u_ram_a (
        .i_clk       (i_clk),
        .i_wr_en     (wr_ok),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_wr_value),
        .i_rd_addr_a (addr00),
        .i_rd_addr_b (addr10),
        .o_rd_data_a (rd00),
        .o_rd_data_b (rd10)
    );

    vnt_ram #(
        .WIDTH (vnt_pkg::VAL_W),
        .DEPTH (CELLS)
    ) u_ram_b (
        .i_clk       (i_clk),
        .i_wr_en     (wr_ok),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_wr_value),
        .i_rd_addr_a (addr01),
        .i_rd_addr_b (addr11),
        .o_rd_data_a (rd01),
        .o_rd_data_b (rd11)
    );

endmodule

`default_nettype wire

>>> rtl/vnt_octave.sv
// Octave datapath: smoothing of the fractions and bilinear blend of the corners.
`timescale 1ns / 1ps
`default_nettype none

module vnt_octave #(
    parameter int FRAC_BITS = vnt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_issue,
    input  wire logic [FRAC_BITS-1:0]        i_fx,
    input  wire logic [FRAC_BITS-1:0]        i_fy,
    input  vnt_pkg::t_corners                i_corners,
    output logic                             o_valid,
    output logic [vnt_pkg::VAL_W-1:0]        o_value,
    output logic                             o_busy
);

    localparam int F  = FRAC_BITS;
    localparam int VW = vnt_pkg::VAL_W;
    localparam int PW = VW + F + 2;
    localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
    localparam logic [F:0]   ONE       = (F+1)'(1) << F;

    // Stage registers.
    logic              r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    logic [F-1:0]      r_s1_fx, r_s1_fy;
    logic [F-1:0]      r_s2_fx, r_s2_fy, r_s2_sqx, r_s2_sqy;
    vnt_pkg::t_corners r_s2_corners, r_s3_corners;
    logic [F-1:0]      r_s3_sx, r_s3_sy;
    logic [VW-1:0]     r_s4_lo, r_s4_hi;
    logic [F-1:0]      r_s4_sy;
    logic [VW-1:0]     r_s5_value;

    // Stage logic.
    logic [2*F-1:0]    s1_sqx, s1_sqy;
    logic [F+1:0]      s2_wx, s2_wy;
    logic [2*F+1:0]    s2_px, s2_py;
    logic [F:0]        s3_wx;
    logic [VW+F+1:0]   s3_lo, s3_hi;
    logic [F:0]        s4_wy;
    logic [VW+F+1:0]   s4_v;

    // Stage 1: square the fractions while the corners come out of the RAMs.
    assign s1_sqx = (2*F)'(r_s1_fx) * (2*F)'(r_s1_fx);
    assign s1_sqy = (2*F)'(r_s1_fy) * (2*F)'(r_s1_fy);

    // Stage 2: finish the smoothstep, f*f*(3-2f).
    assign s2_wx = THREE_ONE - {1'b0, r_s2_fx, 1'b0};
    assign s2_wy = THREE_ONE - {1'b0, r_s2_fy, 1'b0};
    assign s2_px = (2*F+2)'(r_s2_sqx) * (2*F+2)'(s2_wx);
    assign s2_py = (2*F+2)'(r_s2_sqy) * (2*F+2)'(s2_wy);

    // Stage 3: blend along the row direction on both columns.
    assign s3_wx = ONE - {1'b0, r_s3_sx};
    assign s3_lo = PW'(r_s3_corners.c00) * PW'(s3_wx) + PW'(r_s3_corners.c10) * PW'(r_s3_sx);
    assign s3_hi = PW'(r_s3_corners.c01) * PW'(s3_wx) + PW'(r_s3_corners.c11) * PW'(r_s3_sx);

    // Stage 4: blend the two column results.
    assign s4_wy = ONE - {1'b0, r_s4_sy};
    assign s4_v  = PW'(r_s4_lo) * PW'(s4_wy) + PW'(r_s4_hi) * PW'(r_s4_sy);

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    // Data of the stages.
    always_ff @(posedge i_clk) begin
        r_s1_fx      <= i_fx;
        r_s1_fy      <= i_fy;
        r_s2_fx      <= r_s1_fx;
        r_s2_fy      <= r_s1_fy;
        r_s2_sqx     <= s1_sqx[2*F-1:F];
        r_s2_sqy     <= s1_sqy[2*F-1:F];
        r_s2_corners <= i_corners;
        r_s3_sx      <= s2_px[2*F-1:F];
        r_s3_sy      <= s2_py[2*F-1:F];
        r_s3_corners <= r_s2_corners;
        r_s4_lo      <= s3_lo[VW+F-1:F];
        r_s4_hi      <= s3_hi[VW+F-1:F];
        r_s4_sy      <= r_s3_sy;
        r_s5_value   <= s4_v[VW+F-1:F];
    end

    assign o_valid = r_s5_valid;
    assign o_value = r_s5_value;
    assign o_busy  = r_s1_valid | r_s2_valid | r_s3_valid | r_s4_valid | r_s5_valid;

endmodule

`default_nettype wire

>>> rtl/value_noise_turbulence_2d.sv
// Top level: item sequencer, octave accumulator, output register and configuration.
// A write item gives no result and leaves the block ready for the next item.
// An evaluate item issues one octave per cycle into a five-stage octave pipeline,
// which drains before the sum is final; with zero octaves both steps are skipped.
// The sum is then loaded into the output register, and the next item is accepted
// after that load. Reset is synchronous, active low; it restores an octave count
// of 3 and leaves the lattice undefined.
`timescale 1ns / 1ps
`default_nettype none

module value_noise_turbulence_2d #(
    parameter int LATTICE_SIZE = vnt_pkg::LATTICE_SIZE_DEF,
    parameter int FRAC_BITS    = vnt_pkg::FRAC_BITS_DEF,
    parameter int MAX_OCTAVES  = vnt_pkg::MAX_OCTAVES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Item channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_mode,
    input  wire logic [vnt_pkg::COORD_W-1:0]   i_x_coord,
    input  wire logic [vnt_pkg::COORD_W-1:0]   i_y_coord,
    input  wire logic [vnt_pkg::IDX_W-1:0]     i_entry_index,
    input  wire logic [vnt_pkg::VAL_W-1:0]     i_entry_value,
    // Result channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [vnt_pkg::OUT_W-1:0]          o_noise_value,
    // Configuration channel.
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [vnt_pkg::CFG_W-1:0]     i_octave_count
);

    localparam int IW    = $clog2(LATTICE_SIZE);
    localparam int CW    = FRAC_BITS + IW;
    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int ACC_W = vnt_pkg::VAL_W + MAX_OCTAVES;

    vnt_pkg::t_state r_state, n_state;

    logic [CW-1:0]                 r_xs, r_ys;
    logic [OCT_W-1:0]              r_oct_n, r_iss, r_acc_oct;
    logic [ACC_W-1:0]              r_acc;
    logic                          r_out_valid;
    logic [vnt_pkg::OUT_W-1:0]     r_out_value;
    logic [vnt_pkg::CFG_W-1:0]     r_octave_count;

    logic                          in_accept, eval_start, wr_en, issue, out_load;
    logic [OCT_W-1:0]              oct_n_sel, acc_sh;
    logic [63:0]                   x_ext, y_ext;
    vnt_pkg::t_corners             corners;
    logic                          pipe_valid, pipe_busy;
    logic [vnt_pkg::VAL_W-1:0]     pipe_value;

    // Handshakes and item decode.
    assign o_in_ready  = (r_state == vnt_pkg::ST_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign eval_start  = in_accept && (i_mode == vnt_pkg::MODE_EVAL);
    assign wr_en       = in_accept && (i_mode == vnt_pkg::MODE_WRITE);
    assign o_cfg_ready = 1'b1;

    // Octave count limited to what the design supports.
    assign oct_n_sel = (int'(r_octave_count) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES)
                                                            : OCT_W'(r_octave_count);

    // Sign-extended coordinates, cut to the bits that reach the lattice.
    assign x_ext = {{32{i_x_coord[31]}}, i_x_coord};
    assign y_ext = {{32{i_y_coord[31]}}, i_y_coord};

    // Sequencer next state and strobes.
    always_comb begin
        n_state  = r_state;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            vnt_pkg::ST_IDLE: begin
                if (eval_start) begin
                    n_state = (oct_n_sel == '0) ? vnt_pkg::ST_DONE : vnt_pkg::ST_RUN;
                end
            end
            vnt_pkg::ST_RUN: begin
                issue = 1'b1;
                if (r_iss == OCT_W'(r_oct_n - OCT_W'(1))) begin
                    n_state = vnt_pkg::ST_DRAIN;
                end
            end
            vnt_pkg::ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = vnt_pkg::ST_DONE;
                end
            end
            vnt_pkg::ST_DONE: begin
                out_load = !r_out_valid || i_out_ready;
                if (out_load) begin
                    n_state = vnt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vnt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vnt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Coordinates double each octave; octave counters and the running sum.
    assign acc_sh = OCT_W'(MAX_OCTAVES - 1) - r_acc_oct;

    always_ff @(posedge i_clk) begin
        if (eval_start) begin
            r_xs      <= x_ext[CW-1:0];
            r_ys      <= y_ext[CW-1:0];
            r_oct_n   <= oct_n_sel;
            r_iss     <= '0;
            r_acc_oct <= '0;
            r_acc     <= '0;
        end else begin
            if (issue) begin
                r_xs  <= r_xs << 1;
                r_ys  <= r_ys << 1;
                r_iss <= r_iss + OCT_W'(1);
            end
            if (pipe_valid) begin
                r_acc     <= r_acc + (ACC_W'(pipe_value) << acc_sh);
                r_acc_oct <= r_acc_oct + OCT_W'(1);
            end
        end
    end

    // Output register lets the next item in while a result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= r_acc[ACC_W-1 -: vnt_pkg::OUT_W];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_out_value;

    // Octave count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= vnt_pkg::OCT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_octave_count <= i_octave_count;
        end
    end

    // Lattice store; writes only arrive while no evaluation is in flight.
    vnt_lattice #(
        .LATTICE_SIZE (LATTICE_SIZE)
    ) u_lattice (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_index (i_entry_index),
        .i_wr_value (i_entry_value),
        .i_row      (r_xs[CW-1:FRAC_BITS]),
        .i_col      (r_ys[CW-1:FRAC_BITS]),
        .o_corners  (corners)
    );

    // Octave arithmetic pipeline.
    vnt_octave #(
        .FRAC_BITS (FRAC_BITS)
    ) u_octave (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (issue),
        .i_fx      (r_xs[FRAC_BITS-1:0]),
        .i_fy      (r_ys[FRAC_BITS-1:0]),
        .i_corners (corners),
        .o_valid   (pipe_valid),
        .o_value   (pipe_value),
        .o_busy    (pipe_busy)
    );

`ifndef SYNTHESIS
    // Octave results only arrive while an evaluation is in progress.
    a_pipe_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pipe_valid |-> (r_state == vnt_pkg::ST_RUN || r_state == vnt_pkg::ST_DRAIN))
        else $error("octave result outside an evaluation");

    // Issue never runs past the latched octave count.
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vnt_pkg::ST_RUN) |-> (r_iss < r_oct_n))
        else $error("octave issued beyond the count");

    // Every issued octave has been summed before the result is offered.
    a_all_summed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vnt_pkg::ST_DONE) |-> (r_acc_oct == r_oct_n && !pipe_busy))
        else $error("result taken before all octaves were summed");

    // A new result beat only comes from the completion state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == vnt_pkg::ST_DONE))
        else $error("result beat without a finished evaluation");
`endif

endmodule

`default_nettype wire

>>> bench/value_noise_turbulence_2d_test.sv
// Self-checking testbench for the value noise turbulence block, with its own turbulence predictor.
`timescale 1ns / 1ps

module value_noise_turbulence_2d_test;
    import vnt_pkg::*;

    localparam int GRID       = LATTICE_SIZE_DEF;
    localparam int CELLS      = GRID * GRID;
    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int OCT_MAX    = MAX_OCTAVES_DEF;
    localparam int SETTLE     = 24;
    localparam int HOLD_LONG  = 300;
    localparam int CYCLE_CAP  = 2_500_000;
    localparam int PHASE_ITEMS = 140;
    localparam logic [63:0] ONE_Q = 64'd1 << FRAC;
    // Coordinate bits that pick a row or column in some octave, all but the lowest two
    // are kept equal, so every octave lands within SPAN rows and columns of the origin.
    localparam int PIN_HI     = FRAC + $clog2(GRID) - 1;
    localparam int PIN_LO     = FRAC - OCT_MAX + 3;
    localparam int SPAN       = 4;

    // One item on the input channel.
    typedef struct {
        logic               mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDX_W-1:0]   index;
        logic [VAL_W-1:0]   value;
    } t_noise_req;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_mode = MODE_WRITE;
    logic [COORD_W-1:0] in_x = '0;
    logic [COORD_W-1:0] in_y = '0;
    logic [IDX_W-1:0]   in_index = '0;
    logic [VAL_W-1:0]   in_value = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [CFG_W-1:0]   cfg_octaves = OCT_RESET;

    wire                o_in_ready;
    wire                o_out_valid;
    wire                o_cfg_ready;
    wire [OUT_W-1:0]    o_noise_value;

    // Predictor state: lattice contents and the octave count in force.
    logic [VAL_W-1:0]   lattice_mem [CELLS];
    logic [CFG_W-1:0]   oct_cfg = OCT_RESET;

    t_noise_req         req_queue [$];
    logic [OUT_W-1:0]   noise_expected [$];

    int  offered_cnt = 0;
    int  accepted_cnt = 0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    int  rx_holds_asked = 0;
    int  rx_holds_done = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    int  error_count = 0;
    int  cycle_count = 0;

    value_noise_turbulence_2d u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (in_mode),
        .i_x_coord      (in_x),
        .i_y_coord      (in_y),
        .i_entry_index  (in_index),
        .i_entry_value  (in_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_noise_value  (o_noise_value),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_octave_count (cfg_octaves)
    );

    always #10 clk = ~clk;

    // Lattice read with both coordinates wrapped onto the grid.
    function automatic logic [63:0] lattice_at(input logic [63:0] r, input logic [63:0] c);
        int unsigned entry;
        entry = 32'((r & (GRID - 1)) * GRID + (c & (GRID - 1)));
        return {48'd0, lattice_mem[entry]};
    endfunction

    // Cubic ease f*f*(3-2f) in Q0.16, both shifts truncating.
    function automatic logic [63:0] smoothstep_q16(input logic [63:0] f);
        logic [63:0] sq;
        sq = (f * f) >> FRAC;
        return (sq * (3 * ONE_Q - 2 * f)) >> FRAC;
    endfunction

    function automatic logic [63:0] lerp_q16(input logic [63:0] a, input logic [63:0] b,
                                             input logic [63:0] s);
        return (a * (ONE_Q - s) + b * s) >> FRAC;
    endfunction

    // Turbulence sum over the active octaves, truncated to Q1.16.
    function automatic logic [OUT_W-1:0] turbulence_at(input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y,
                                                       input int octaves);
        logic [63:0] xs, ys, ux, uy, rx, cy, sx, sy, lo, hi, acc;
        int n;
        xs  = {{32{x[COORD_W-1]}}, x};
        ys  = {{32{y[COORD_W-1]}}, y};
        n   = (octaves > OCT_MAX) ? OCT_MAX : octaves;
        acc = '0;
        for (int i = 0; i < n; i++) begin
            ux = xs << i;
            uy = ys << i;
            rx = ux >> FRAC;
            cy = uy >> FRAC;
            sx = smoothstep_q16(ux & (ONE_Q - 1));
            sy = smoothstep_q16(uy & (ONE_Q - 1));
            lo = lerp_q16(lattice_at(rx, cy), lattice_at(rx + 1, cy), sx);
            hi = lerp_q16(lattice_at(rx, cy + 1), lattice_at(rx + 1, cy + 1), sx);
            acc += lerp_q16(lo, hi, sy) << (OCT_MAX - 1 - i);
        end
        return acc[OCT_MAX-1 +: OUT_W];
    endfunction

    // Idle lengths: mostly none or short, now and then long.
    function automatic int draw_gap(input bit quiet);
        int p;
        p = $urandom_range(0, 99);
        if (quiet || p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Coordinates: random high bits, sign-extended, or with a fraction at its edges.
    // All but the lowest two row and column bits stay either all clear or all set.
    function automatic logic [COORD_W-1:0] pick_coord();
        logic [COORD_W-1:0] r;
        logic [PIN_LO-1:0]  frac_picks [4];
        frac_picks = '{'0, PIN_LO'(1), PIN_LO'(1) << (PIN_LO - 1), '1};
        r = $urandom();
        case ($urandom_range(0, 2))
            0: ;
            1: r[COORD_W-1:PIN_HI+1] = {(COORD_W-1-PIN_HI){r[PIN_HI]}};
            default: r[PIN_LO-1:0] = frac_picks[$urandom_range(0, 3)];
        endcase
        r[PIN_HI:PIN_LO] = {(PIN_HI-PIN_LO+1){r[PIN_HI]}};
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return VAL_W'($urandom());
        endcase
    endfunction

    function automatic t_noise_req write_req(input int idx, input logic [VAL_W-1:0] v);
        t_noise_req r;
        r.mode  = MODE_WRITE;
        r.x     = $urandom();
        r.y     = $urandom();
        r.index = IDX_W'(idx);
        r.value = v;
        return r;
    endfunction

    function automatic t_noise_req eval_req(input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
        t_noise_req r;
        r.mode  = MODE_EVAL;
        r.x     = x;
        r.y     = y;
        r.index = IDX_W'($urandom());
        r.value = VAL_W'($urandom());
        return r;
    endfunction

    // Evaluations at the coordinate extremes and around the wrap point.
    task automatic push_directed_evals();
        req_queue.push_back(eval_req(32'h0000_0000, 32'h0000_0000));
        req_queue.push_back(eval_req(32'h0000_0FFF, 32'h0000_0FFF));
        req_queue.push_back(eval_req(32'h0000_0800, 32'hFFFF_F800));
        req_queue.push_back(eval_req(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        req_queue.push_back(eval_req(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        req_queue.push_back(eval_req(32'h8000_0000, 32'h8000_0000));
        req_queue.push_back(eval_req(32'h8000_0000, 32'h7FFF_FFFF));
        req_queue.push_back(eval_req(32'h003F_F000, 32'hFFC0_0001));
    endtask

    task automatic push_random(input int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 85)
                req_queue.push_back(eval_req(pick_coord(), pick_coord()));
            else
                req_queue.push_back(write_req($urandom_range(0, CELLS - 1), pick_value()));
        end
    endtask

    // Register write, issued only while the block is idle.
    task automatic set_octaves(input logic [CFG_W-1:0] n);
        @(negedge clk);
        cfg_valid   <= 1'b1;
        cfg_octaves <= n;
        do @(posedge clk); while (!o_cfg_ready);
        oct_cfg = n;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every item is taken and every result has come, then let the block settle.
    task automatic wait_drained();
        while (req_queue.size() != 0 || in_valid || noise_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Input driver: one item per beat, random gaps after each beat.
    always @(negedge clk) begin
        t_noise_req req;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (accepted_cnt == offered_cnt) begin
            if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (req_queue.size() != 0) begin
                req = req_queue.pop_front();
                in_mode  <= req.mode;
                in_x     <= req.x;
                in_y     <= req.y;
                in_index <= req.index;
                in_value <= req.value;
                in_valid <= 1'b1;
                offered_cnt++;
                tx_gap = draw_gap(tx_burst);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus long hold-offs on request.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (rx_holds_done != rx_holds_asked) begin
            rx_holds_done++;
            rx_stall = HOLD_LONG;
            out_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            out_ready <= 1'b0;
        end else begin
            rx_stall = draw_gap(rx_burst);
            out_ready <= (rx_stall == 0);
        end
    end

    // Monitor: predict on each input beat, check each result beat.
    always @(posedge clk) begin
        logic [OUT_W-1:0] want;
        cycle_count++;
        if (rst_n && in_valid && o_in_ready) begin
            accepted_cnt++;
            if (in_mode == MODE_WRITE) begin
                if (in_index < CELLS)
                    lattice_mem[in_index] = in_value;
            end else begin
                noise_expected.push_back(turbulence_at(in_x, in_y, int'(oct_cfg)));
            end
        end
        if (rst_n && o_out_valid && out_ready) begin
            if (noise_expected.size() == 0) begin
                if (error_count < 10)
                    $display("unexpected result beat: noise_value %h", o_noise_value);
                error_count++;
            end else begin
                want = noise_expected.pop_front();
                if (o_noise_value !== want) begin
                    if (error_count < 10)
                        $display("noise_value mismatch: expected %h, got %h",
                                 want, o_noise_value);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the cycle counter.
    initial begin
        while (cycle_count < CYCLE_CAP)
            @(posedge clk);
        $display("value_noise_turbulence_2d_test: FAIL");
        $finish;
    end

    // Stimulus sequence.
    initial begin
        logic [CFG_W-1:0] settings [8];
        settings = '{3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4, 3'd6, 3'd7};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Load every entry that an evaluation can reach, around the origin and the wrap.
        for (int r = -SPAN; r <= SPAN; r++)
            for (int c = -SPAN; c <= SPAN; c++)
                req_queue.push_back(write_req(((r + GRID) % GRID) * GRID + (c + GRID) % GRID,
                                              pick_value()));
        wait_drained();

        // Extreme lattice values at the corners of the grid, then directed evaluations.
        req_queue.push_back(write_req(0, 16'hFFFF));
        req_queue.push_back(write_req(1, 16'h0000));
        req_queue.push_back(write_req(GRID, 16'h0000));
        req_queue.push_back(write_req(GRID + 1, 16'hFFFF));
        req_queue.push_back(write_req(GRID - 1, 16'h0000));
        req_queue.push_back(write_req(CELLS - GRID, 16'hFFFF));
        req_queue.push_back(write_req(CELLS - 1, 16'hFFFF));
        push_directed_evals();
        wait_drained();

        foreach (settings[p]) begin
            set_octaves(settings[p]);
            tx_burst = (p == 1 || p == 3);
            rx_burst = (p == 3);
            if (p == 1) begin
                // Hold results back while items keep coming, so the block backs up.
                rx_holds_asked++;
                push_directed_evals();
            end
            push_random(PHASE_ITEMS);
            wait_drained();
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;

        if (noise_expected.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("value_noise_turbulence_2d_test: PASS");
        else
            $display("value_noise_turbulence_2d_test: FAIL");
        $finish;
    end

endmodule
